### rtl/wsq_pkg.sv
// Shared types and constants for the wall segment qualifier.
// Holds the item structs, the configuration register codes and the datapath widths.
// No dependencies.
package wsq_pkg;

	// Input coordinate width and fixed-point fraction bits
	localparam int CW        = 16;
	localparam int FRAC_BITS = 10;

	// Result and register widths
	localparam int RW    = 16;
	localparam int OFF_W = 15;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// Robot-frame coordinates: negation plus offset needs two extra bits
	localparam int XW     = CW + 2;
	// Multiplier operand: a coordinate difference
	localparam int MW     = XW + 1;
	localparam int PW     = 2 * MW;
	// Sum of squares and its integer root
	localparam int SQ_W   = 2 * XW;
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	// Shared subtractor: shifted square-root remainder plus a borrow bit
	localparam int SUB_W  = REM_W + 3;
	// |x1*y2 - x2*y1| stays below 2^(2*CW); signed form carries two spare bits
	localparam int QW      = 2 * CW;
	localparam int CROSS_W = QW + 2;

	localparam int CNT_W     = $clog2(QW);
	localparam int MUL_STEPS = 5;

	localparam logic [RW-1:0] SAT = '1;

	// Register reset values: 5.0, 1.0 and 0.415 in the fixed-point format
	localparam logic [CFG_W-1:0] RANGE_LIMIT_RST = CFG_W'(5 << FRAC_BITS);
	localparam logic [CFG_W-1:0] MIN_LENGTH_RST  = CFG_W'(1 << FRAC_BITS);
	localparam logic [OFF_W-1:0] MOUNT_OFFSET_RST =
		OFF_W'(((415 << FRAC_BITS) + 500) / 1000);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_OFFSET = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_SQRT = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	typedef struct packed {
		logic                 sensor;
		logic                 has_segment;
		logic                 coords_valid;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic                 last_in_list;
	} in_item_t;

	typedef struct packed {
		logic          accepted;
		logic [RW-1:0] line_distance;
		logic [RW-1:0] segment_length;
		logic          frame_done;
		logic          nearest_found;
		logic [RW-1:0] nearest_distance;
	} out_item_t;

endpackage

### rtl/wall_segment_qualifier.sv
// Wall segment qualifier: top level with sequencer and shared arithmetic units.
// Depends on wsq_pkg for item structs, register codes and widths.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  in       | input     | in_valid/in_stall  | wsq_pkg::in_item_t  in_data
//  out      | output    | out_valid/out_stall| wsq_pkg::out_item_t out_data
//  cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// A measured segment passes the accept step, 5 steps through the one 19x19 multiplier,
// 18 square-root steps and 32 division steps on the shared subtractor, and the finish step.
// Items that are not measured (ignored sensor, empty marker, bad or own-side coordinates)
// go from accept straight to the finish step; a zero-length segment skips the division.
// in_stall is high from acceptance until the result is written to the output register.
// A waiting result stalls the finish step only, so the next item may already be at work.
// arst_n clears the sequencer, the frame state and the registers to their defaults.
module wall_segment_qualifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  wsq_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output wsq_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [wsq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsq_pkg::CFG_W-1:0]       cfg_data
);

	// Control state
	wsq_pkg::state_t                 state_q;
	logic [wsq_pkg::CNT_W-1:0]       cnt_q;
	logic                            f0_q, f1_q, bv_q;
	logic [wsq_pkg::RW-1:0]          best_q;
	logic                            out_valid_q;
	logic [wsq_pkg::CFG_W-1:0]       range_q, minlen_q;
	logic [wsq_pkg::OFF_W-1:0]       offset_q;

	// Datapath registers
	logic                                sensor_q, last_q, ign_q, meas_q;
	logic signed [wsq_pkg::XW-1:0]       x1_q, y1_q, x2_q, y2_q;
	logic signed [wsq_pkg::PW-1:0]       prod_q;
	logic [wsq_pkg::SQ_W-1:0]            sumsq_q;
	logic signed [wsq_pkg::CROSS_W-1:0]  cross_q;
	logic [wsq_pkg::REM_W-1:0]           rem_q;
	logic [wsq_pkg::ROOT_W-1:0]          root_q;
	logic [wsq_pkg::QW-1:0]              quo_q;
	wsq_pkg::out_item_t                  out_q;

	// Transform of the incoming item into the robot frame
	logic signed [wsq_pkg::XW-1:0] sx, sy, ex, ey, off;
	logic signed [wsq_pkg::XW-1:0] x1_w, y1_w, x2_w, y2_w;
	logic                          own_side, in_acc, ign_w, meas_w;

	assign sx  = {{(wsq_pkg::XW-wsq_pkg::CW){in_data.start_x[wsq_pkg::CW-1]}}, in_data.start_x};
	assign sy  = {{(wsq_pkg::XW-wsq_pkg::CW){in_data.start_y[wsq_pkg::CW-1]}}, in_data.start_y};
	assign ex  = {{(wsq_pkg::XW-wsq_pkg::CW){in_data.end_x[wsq_pkg::CW-1]}}, in_data.end_x};
	assign ey  = {{(wsq_pkg::XW-wsq_pkg::CW){in_data.end_y[wsq_pkg::CW-1]}}, in_data.end_y};
	assign off = wsq_pkg::XW'(offset_q);

	always_comb begin
		if (in_data.sensor) begin
			x1_w     = -sy;
			y1_w     = sx + off;
			x2_w     = -ey;
			y2_w     = ex + off;
			own_side = (y1_w < off) && (y2_w < off);
		end else begin
			x1_w     = sy;
			y1_w     = -sx - off;
			x2_w     = ey;
			y2_w     = -ex - off;
			own_side = (y1_w > -off) && (y2_w > -off);
		end
	end

	assign in_stall = (state_q != wsq_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign ign_w    = in_data.sensor ? f1_q : f0_q;
	assign meas_w   = !ign_w && in_data.has_segment && in_data.coords_valid && !own_side;

	// Shared multiplier: squares of the differences, then the two cross terms
	logic signed [wsq_pkg::MW-1:0] mul_a, mul_b, dxs, dys;
	logic signed [wsq_pkg::PW-1:0] mul_p;

	assign dxs = {x2_q[wsq_pkg::XW-1], x2_q} - {x1_q[wsq_pkg::XW-1], x1_q};
	assign dys = {y2_q[wsq_pkg::XW-1], y2_q} - {y1_q[wsq_pkg::XW-1], y1_q};

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin
				mul_a = dxs;
				mul_b = dxs;
			end
			3'd1: begin
				mul_a = dys;
				mul_b = dys;
			end
			3'd2: begin
				mul_a = {x1_q[wsq_pkg::XW-1], x1_q};
				mul_b = {y2_q[wsq_pkg::XW-1], y2_q};
			end
			3'd3: begin
				mul_a = {x2_q[wsq_pkg::XW-1], x2_q};
				mul_b = {y1_q[wsq_pkg::XW-1], y1_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Shared subtractor: square-root trial in SQRT, divisor trial in DIV
	logic [wsq_pkg::REM_W+1:0]   sq_rem;
	logic [wsq_pkg::ROOT_W:0]    dv_rem;
	logic [wsq_pkg::SUB_W-1:0]   sub_a, sub_b, sub_d;
	logic                        ge;
	logic [wsq_pkg::ROOT_W-1:0]  root_n;
	logic [wsq_pkg::CROSS_W-1:0] cross_mag;

	assign sq_rem = {rem_q, sumsq_q[wsq_pkg::SQ_W-1 -: 2]};
	assign dv_rem = {rem_q[wsq_pkg::ROOT_W-1:0], quo_q[wsq_pkg::QW-1]};

	always_comb begin
		if (state_q == wsq_pkg::S_DIV) begin
			sub_a = wsq_pkg::SUB_W'(dv_rem);
			sub_b = wsq_pkg::SUB_W'(root_q);
		end else begin
			sub_a = wsq_pkg::SUB_W'(sq_rem);
			sub_b = wsq_pkg::SUB_W'({root_q, 2'b01});
		end
	end

	assign sub_d  = sub_a - sub_b;
	assign ge     = !sub_d[wsq_pkg::SUB_W-1];
	assign root_n = {root_q[wsq_pkg::ROOT_W-2:0], ge};
	assign cross_mag = cross_q[wsq_pkg::CROSS_W-1] ? wsq_pkg::CROSS_W'(-cross_q) :
		wsq_pkg::CROSS_W'(cross_q);

	// Finish step: tests, nearest tracking and frame close
	logic                   len_nz, acc_n, bv_n, f0_n, f1_n, done_n, fin_go;
	logic [wsq_pkg::RW-1:0] dist_sat, len_sat, best_n;
	wsq_pkg::out_item_t     res_n;

	assign len_nz   = (root_q != '0);
	assign acc_n    = meas_q && len_nz && (quo_q < wsq_pkg::QW'(range_q)) &&
		(root_q > wsq_pkg::ROOT_W'(minlen_q));
	assign dist_sat = (!len_nz || quo_q > wsq_pkg::QW'(wsq_pkg::SAT)) ? wsq_pkg::SAT :
		quo_q[wsq_pkg::RW-1:0];
	assign len_sat  = (root_q > wsq_pkg::ROOT_W'(wsq_pkg::SAT)) ? wsq_pkg::SAT :
		root_q[wsq_pkg::RW-1:0];
	assign best_n   = (acc_n && (!bv_q || dist_sat < best_q)) ? dist_sat : best_q;
	assign bv_n     = bv_q || acc_n;
	assign f0_n     = f0_q || (last_q && !sensor_q);
	assign f1_n     = f1_q || (last_q && sensor_q);
	assign done_n   = !ign_q && f0_n && f1_n;
	assign fin_go   = (state_q == wsq_pkg::S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		res_n.accepted         = acc_n;
		res_n.line_distance    = meas_q ? dist_sat : '0;
		res_n.segment_length   = meas_q ? len_sat : '0;
		res_n.frame_done       = done_n;
		res_n.nearest_found    = done_n && bv_n;
		res_n.nearest_distance = done_n ? best_n : '0;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q  <= wsq_pkg::RANGE_LIMIT_RST;
			minlen_q <= wsq_pkg::MIN_LENGTH_RST;
			offset_q <= wsq_pkg::MOUNT_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wsq_pkg::CFG_RANGE_LIMIT:  range_q  <= cfg_data;
				wsq_pkg::CFG_MIN_LENGTH:   minlen_q <= cfg_data;
				wsq_pkg::CFG_MOUNT_OFFSET: offset_q <= cfg_data[wsq_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsq_pkg::S_IDLE;
			cnt_q       <= '0;
			f0_q        <= 1'b0;
			f1_q        <= 1'b0;
			bv_q        <= 1'b0;
			best_q      <= wsq_pkg::SAT;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				wsq_pkg::S_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= meas_w ? wsq_pkg::S_MUL : wsq_pkg::S_FIN;
					end
				end
				wsq_pkg::S_MUL: begin
					if (cnt_q == wsq_pkg::CNT_W'(wsq_pkg::MUL_STEPS - 1)) begin
						cnt_q   <= wsq_pkg::CNT_W'(wsq_pkg::ROOT_W - 1);
						state_q <= wsq_pkg::S_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				wsq_pkg::S_SQRT: begin
					if (cnt_q == '0) begin
						// zero length: no division, distance saturates
						cnt_q   <= wsq_pkg::CNT_W'(wsq_pkg::QW - 1);
						state_q <= (root_n == '0) ? wsq_pkg::S_FIN : wsq_pkg::S_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				wsq_pkg::S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= wsq_pkg::S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				wsq_pkg::S_FIN: begin
					if (fin_go) begin
						state_q <= wsq_pkg::S_IDLE;
						if (!ign_q) begin
							if (done_n) begin
								f0_q   <= 1'b0;
								f1_q   <= 1'b0;
								bv_q   <= 1'b0;
								best_q <= wsq_pkg::SAT;
							end else begin
								f0_q   <= f0_n;
								f1_q   <= f1_n;
								bv_q   <= bv_n;
								best_q <= best_n;
							end
						end
					end
				end
				default: state_q <= wsq_pkg::S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			wsq_pkg::S_IDLE: begin
				if (in_acc) begin
					sensor_q <= in_data.sensor;
					last_q   <= in_data.last_in_list;
					ign_q    <= ign_w;
					meas_q   <= meas_w;
					x1_q     <= x1_w;
					y1_q     <= y1_w;
					x2_q     <= x2_w;
					y2_q     <= y2_w;
				end
			end
			wsq_pkg::S_MUL: begin
				prod_q <= mul_p;
				case (cnt_q[2:0])
					3'd1: sumsq_q <= prod_q[wsq_pkg::SQ_W-1:0];
					3'd2: sumsq_q <= sumsq_q + prod_q[wsq_pkg::SQ_W-1:0];
					3'd3: cross_q <= prod_q[wsq_pkg::CROSS_W-1:0];
					3'd4: cross_q <= cross_q - prod_q[wsq_pkg::CROSS_W-1:0];
					default: ;
				endcase
				if (cnt_q == wsq_pkg::CNT_W'(wsq_pkg::MUL_STEPS - 1)) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			wsq_pkg::S_SQRT: begin
				root_q  <= root_n;
				sumsq_q <= {sumsq_q[wsq_pkg::SQ_W-3:0], 2'b00};
				if (cnt_q == '0) begin
					// hold the root; start the quotient from |x1*y2 - x2*y1|
					rem_q <= '0;
					quo_q <= cross_mag[wsq_pkg::QW-1:0];
				end else begin
					rem_q <= ge ? sub_d[wsq_pkg::REM_W-1:0] : sq_rem[wsq_pkg::REM_W-1:0];
				end
			end
			wsq_pkg::S_DIV: begin
				rem_q <= wsq_pkg::REM_W'(ge ? sub_d[wsq_pkg::ROOT_W-1:0] :
					dv_rem[wsq_pkg::ROOT_W-1:0]);
				quo_q <= {quo_q[wsq_pkg::QW-2:0], ge};
			end
			wsq_pkg::S_FIN: begin
				if (fin_go) begin
					out_q <= ign_q ? '0 : res_n;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && done_n |=> !f0_q && !f1_q && !bv_q && best_q == wsq_pkg::SAT)
		else $error("frame close left tracking state behind");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsq_pkg::S_DIV |-> root_q != '0)
		else $error("division entered with zero length");

	a_no_close_no_nearest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_done |->
		!out_data.nearest_found && out_data.nearest_distance == '0)
		else $error("nearest distance reported without frame close");

	a_accept_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |->
		out_data.segment_length != '0 && out_data.line_distance != wsq_pkg::SAT)
		else $error("accepted segment with zero length or saturated distance");
`endif

endmodule

### test/wsq_checker.sv
`timescale 1ns / 100ps
// Result checker for the wall segment qualifier: watches the input, output and register ports.
// Predicts every result from the accepted items and compares field by field.
// Depends on wsq_pkg for the item structs and register codes.
module wsq_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  wsq_pkg::in_item_t             in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  wsq_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [wsq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsq_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            frames_closed,
	output int                            segments_accepted
);
	import wsq_pkg::*;

	logic [RW-1:0]    range_limit;
	logic [RW-1:0]    min_length;
	logic [OFF_W-1:0] mount_offset;

	logic          right_done;
	logic          left_done;
	logic [RW-1:0] nearest_so_far;
	logic          nearest_valid;

	out_item_t expected_results[$];
	int        results_seen;

	function automatic longint int_sqrt(longint n);
		longint root;
		longint trial;
		root = 0;
		for (int i = 20; i >= 0; i--) begin
			trial = root | (longint'(1) << i);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [RW-1:0] sat16(longint v);
		return (v > longint'(SAT)) ? SAT : v[RW-1:0];
	endfunction

	// One item through the qualifier: measure, qualify, track the nearest line, close frames
	function automatic out_item_t qualify_segment(in_item_t it);
		out_item_t r;
		longint    sx, sy, ex, ey, off;
		longint    x1, y1, x2, y2, dx, dy, cross_prod, seg_len, line_dist;
		logic      own_side;
		r = '0;
		if (it.sensor ? left_done : right_done)
			return r;
		if (it.has_segment && it.coords_valid) begin
			sx  = $signed(it.start_x);
			sy  = $signed(it.start_y);
			ex  = $signed(it.end_x);
			ey  = $signed(it.end_y);
			off = longint'(mount_offset);
			if (!it.sensor) begin
				x1 = sy;
				y1 = -sx - off;
				x2 = ey;
				y2 = -ex - off;
				own_side = (y1 > -off) && (y2 > -off);
			end else begin
				x1 = -sy;
				y1 = sx + off;
				x2 = -ey;
				y2 = ex + off;
				own_side = (y1 < off) && (y2 < off);
			end
			if (!own_side) begin
				dx = x2 - x1;
				dy = y2 - y1;
				seg_len = int_sqrt(dx * dx + dy * dy);
				cross_prod = x1 * y2 - x2 * y1;
				if (cross_prod < 0)
					cross_prod = -cross_prod;
				line_dist = (seg_len == 0) ? longint'(SAT) : cross_prod / seg_len;
				r.segment_length = sat16(seg_len);
				r.line_distance  = sat16(line_dist);
				// compare on the unsaturated values
				if (seg_len != 0 && line_dist < longint'(range_limit) &&
				    seg_len > longint'(min_length)) begin
					r.accepted = 1'b1;
					if (!nearest_valid || sat16(line_dist) < nearest_so_far)
						nearest_so_far = sat16(line_dist);
					nearest_valid = 1'b1;
				end
			end
		end
		if (it.last_in_list) begin
			if (it.sensor)
				left_done = 1'b1;
			else
				right_done = 1'b1;
		end
		if (right_done && left_done) begin
			r.frame_done       = 1'b1;
			r.nearest_found    = nearest_valid;
			r.nearest_distance = nearest_so_far;
			right_done     = 1'b0;
			left_done      = 1'b0;
			nearest_so_far = SAT;
			nearest_valid  = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t made;
		if (!arst_n) begin
			range_limit       = RANGE_LIMIT_RST;
			min_length        = MIN_LENGTH_RST;
			mount_offset      = MOUNT_OFFSET_RST;
			right_done        = 1'b0;
			left_done         = 1'b0;
			nearest_so_far    = SAT;
			nearest_valid     = 1'b0;
			results_seen      = 0;
			fail_count        = 0;
			frames_closed     = 0;
			segments_accepted = 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_LIMIT:  range_limit  = cfg_data;
					CFG_MIN_LENGTH:   min_length   = cfg_data;
					CFG_MOUNT_OFFSET: mount_offset = cfg_data[OFF_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing pending",
						results_seen));
				end else begin
					want = expected_results.pop_front();
					if (out_data.accepted !== want.accepted)
						report_mismatch($sformatf("result %0d accepted %0b, want %0b",
							results_seen, out_data.accepted, want.accepted));
					if (out_data.line_distance !== want.line_distance)
						report_mismatch($sformatf("result %0d line_distance %0d, want %0d",
							results_seen, out_data.line_distance, want.line_distance));
					if (out_data.segment_length !== want.segment_length)
						report_mismatch($sformatf("result %0d segment_length %0d, want %0d",
							results_seen, out_data.segment_length, want.segment_length));
					if (out_data.frame_done !== want.frame_done)
						report_mismatch($sformatf("result %0d frame_done %0b, want %0b",
							results_seen, out_data.frame_done, want.frame_done));
					if (out_data.nearest_found !== want.nearest_found)
						report_mismatch($sformatf("result %0d nearest_found %0b, want %0b",
							results_seen, out_data.nearest_found, want.nearest_found));
					if (out_data.nearest_distance !== want.nearest_distance)
						report_mismatch($sformatf("result %0d nearest_distance %0d, want %0d",
							results_seen, out_data.nearest_distance,
							want.nearest_distance));
				end
				results_seen++;
			end
			if (in_valid && !in_stall) begin
				made = qualify_segment(in_data);
				expected_results = {expected_results, made};
				if (made.frame_done)
					frames_closed++;
				if (made.accepted)
					segments_accepted++;
			end
			pending <= expected_results.size();
		end
	end

endmodule

### test/tb_wall_segment_qualifier.sv
`timescale 1ns / 100ps
// Top of the wall segment qualifier testbench: clock, reset, stimulus and verdict.
// Depends on wsq_pkg, the block itself and wsq_checker, which predicts and compares.
module tb_wall_segment_qualifier;
	import wsq_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 106;
	localparam int MAX_GAP      = 13;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE_LIMIT;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int   fail_count;
	int   pending;
	int   frames_closed;
	int   segments_accepted;
	int   cycle_count = 0;
	int   items_sent  = 0;
	int   settings_run = 1;
	int   stall_left  = 0;
	logic no_idle     = 1'b0;

	wall_segment_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wsq_checker scoreboard (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_data           (in_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_data          (out_data),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.fail_count        (fail_count),
		.pending           (pending),
		.frames_closed     (frames_closed),
		.segments_accepted (segments_accepted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Receiver: a fresh stall count for every result taken
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			stall_left = no_idle ? 0 : int'($urandom_range(MAX_GAP, 0));
		else if (stall_left > 0)
			stall_left--;
		out_stall <= (stall_left != 0);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("tb_wall_segment_qualifier NOT OK");
		$finish;
	end

	function automatic in_item_t make_item(logic s, logic hs, logic cv, int sx, int sy,
			int ex, int ey, logic last);
		in_item_t it;
		it.sensor       = s;
		it.has_segment  = hs;
		it.coords_valid = cv;
		it.start_x      = 16'(sx);
		it.start_y      = 16'(sy);
		it.end_x        = 16'(ex);
		it.end_y        = 16'(ey);
		it.last_in_list = last;
		return it;
	endfunction

	function automatic logic [CW-1:0] rand_coord(int lo, int hi);
		return CW'(lo + int'($urandom_range(hi - lo, 0)));
	endfunction

	// Mostly wall-like segments in front of the sensor, with a share of odd ones
	function automatic in_item_t rand_segment(logic s, logic last);
		in_item_t it;
		int       kind;
		it = make_item(s, 1'b1, 1'b1, 0, 0, 0, 0, last);
		it.start_x = rand_coord(-1500, 7000);
		it.start_y = rand_coord(-7000, 7000);
		it.end_x   = rand_coord(-1500, 7000);
		it.end_y   = rand_coord(-7000, 7000);
		kind = $urandom_range(99, 0);
		if (kind < 18) begin
			it.start_x = CW'($urandom);
			it.start_y = CW'($urandom);
			it.end_x   = CW'($urandom);
			it.end_y   = CW'($urandom);
			if (kind < 4)
				it.has_segment = 1'b0;
			else if (kind < 8)
				it.coords_valid = 1'b0;
		end else if (kind < 23) begin
			it.end_x = it.start_x;
			it.end_y = it.start_y;
		end else if (kind < 27) begin
			it.end_y = it.start_y;
		end else if (kind < 30) begin
			it.end_x = it.start_x;
		end else if (kind < 36) begin
			it.start_x = rand_coord(-6000, -1);
			it.end_x   = rand_coord(-6000, -1);
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(MAX_GAP, 0));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Hold the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] ml,
			input logic [OFF_W-1:0] mo);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RANGE_LIMIT;
		cfg_data  <= rl;
		@(posedge clk);
		cfg_index <= CFG_MIN_LENGTH;
		cfg_data  <= ml;
		@(posedge clk);
		cfg_index <= CFG_MOUNT_OFFSET;
		cfg_data  <= CFG_W'(mo);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_frames(input int budget);
		int       sent;
		int       n_right, n_left, i_right, i_left;
		logic     s;
		logic     ending;
		in_item_t it;
		sent = 0;
		while (sent < budget) begin
			no_idle = ($urandom_range(5, 0) == 0);
			n_right = $urandom_range(6, 1);
			n_left  = $urandom_range(6, 1);
			i_right = 0;
			i_left  = 0;
			while (i_right < n_right || i_left < n_left) begin
				if (i_right == n_right)
					s = 1'b1;
				else if (i_left == n_left)
					s = 1'b0;
				else
					s = 1'($urandom_range(1, 0));
				ending = s ? (i_left == n_left - 1) : (i_right == n_right - 1);
				it = rand_segment(s, ending);
				if ((s ? i_left : i_right) == 0 && $urandom_range(7, 0) == 0)
					it.has_segment = 1'b0;
				send_item(it);
				sent++;
				if (s)
					i_left++;
				else
					i_right++;
				// poke a finished sensor while the other one is still open
				if (ending && (s ? (i_right < n_right) : (i_left < n_left)) &&
				    $urandom_range(9, 0) == 0)
					send_item(rand_segment(s, 1'($urandom_range(1, 0))));
			end
			// stray item between frames: may leave the next frame half closed
			if ($urandom_range(19, 0) == 0) begin
				send_item(rand_segment(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0))));
				sent++;
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] rl, ml;
		logic [OFF_W-1:0] mo;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset register values
		send_item(make_item(1'b0, 1'b1, 1'b1, 1024, -2048, 1024, 2048, 1'b0));
		send_item(make_item(1'b1, 1'b1, 1'b1, 2048, -3000, 2048, 3000, 1'b1));
		send_item(make_item(1'b1, 1'b1, 1'b1, 1024, 0, 1024, 1024, 1'b0));
		send_item(make_item(1'b0, 1'b0, 1'b1, 0, 0, 0, 0, 1'b1));
		send_item(make_item(1'b0, 1'b1, 1'b1, 500, 500, 500, 500, 1'b0));
		send_item(make_item(1'b0, 1'b1, 1'b0, 1024, -2048, 1024, 2048, 1'b0));
		send_item(make_item(1'b0, 1'b1, 1'b1, -100, -2000, -200, 2000, 1'b0));
		send_item(make_item(1'b1, 1'b1, 1'b1, -100, -2000, -300, 2000, 1'b0));
		send_item(make_item(1'b0, 1'b1, 1'b1, 32767, -32768, -32768, 32767, 1'b0));
		send_item(make_item(1'b1, 1'b1, 1'b1, -32768, -32768, 32767, 32767, 1'b0));
		send_item(make_item(1'b0, 1'b1, 1'b1, 32767, 32767, 32767, -32768, 1'b0));
		send_item(make_item(1'b1, 1'b1, 1'b1, 2000, 1000, 2000, 1000, 1'b0));
		send_item(make_item(1'b1, 1'b1, 1'b1, 1000, 1500, 4000, 1500, 1'b0));
		send_item(make_item(1'b0, 1'b1, 1'b1, -32768, -32768, -32768, -32768, 1'b1));
		send_item(make_item(1'b1, 1'b1, 1'b1, 1, 1, 0, 0, 1'b1));
		send_item(make_item(1'b0, 1'b0, 1'b1, 0, 0, 0, 0, 1'b1));
		send_item(make_item(1'b1, 1'b0, 1'b1, 0, 0, 0, 0, 1'b1));
		send_item(make_item(1'b0, 1'b1, 1'b1, 0, 0, 1024, 0, 1'b1));
		send_item(make_item(1'b1, 1'b1, 1'b1, 0, 0, 2048, 0, 1'b1));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin rl = '1; ml = '0; mo = '1; end
				1: begin rl = '0; ml = '1; mo = '0; end
				2: begin rl = 16'd1; ml = '0; mo = '0; end
				6: begin rl = CFG_W'($urandom); ml = CFG_W'($urandom); mo = OFF_W'($urandom); end
				7: begin rl = RANGE_LIMIT_RST; ml = MIN_LENGTH_RST; mo = MOUNT_OFFSET_RST; end
				default: begin
					rl = CFG_W'($urandom_range(12000, 1000));
					ml = CFG_W'($urandom_range(3000, 0));
					mo = OFF_W'($urandom_range(1500, 0));
				end
			endcase
			write_config(rl, ml, mo);
			settings_run++;
			run_frames(PHASE_ITEMS);
			drain();
		end

		// tail: anything arriving now is unexpected
		repeat (100) @(posedge clk);
		$display("Sent %0d items under %0d register settings with random gaps and stalls;",
			items_sent, settings_run);
		$display("%0d frames closed and %0d segments qualified along the way.",
			frames_closed, segments_accepted);
		if (fail_count == 0 && pending == 0)
			$display("tb_wall_segment_qualifier OK");
		else
			$display("tb_wall_segment_qualifier NOT OK");
		$finish;
	end

endmodule

### filelist.f
rtl/wsq_pkg.sv
rtl/wall_segment_qualifier.sv
test/wsq_checker.sv
test/tb_wall_segment_qualifier.sv
